### rtl/ttl_lru_cache_with_miss_coalescing_macros.svh
// assertion macros for the ttl lru cache
// used by the top level only
`ifndef TTL_LRU_CACHE_WITH_MISS_COALESCING_MACROS_SVH
`define TTL_LRU_CACHE_WITH_MISS_COALESCING_MACROS_SVH
`define TLC_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("tlc check");
`define TLC_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("tlc check");
`endif

### rtl/tlc_pkg.sv
// types and constants of the ttl lru cache
// no dependencies
package tlc_pkg;
  localparam int ENTRIES = 16;
  localparam int PENDING_SLOTS = 8;
  localparam int EIDX_BITS = $clog2(ENTRIES);
  localparam int PIDX_BITS = $clog2(PENDING_SLOTS);
  localparam int CNT_BITS = EIDX_BITS + 1;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_FILL = 2'd1;
  localparam logic [1:0] ACT_INVAL = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam logic [2:0] OUT_HIT = 3'd0;
  localparam logic [2:0] OUT_LOAD = 3'd1;
  localparam logic [2:0] OUT_WAIT = 3'd2;
  localparam logic [2:0] OUT_RECUR = 3'd3;
  localparam logic [2:0] OUT_FILL = 3'd4;
  localparam logic [2:0] OUT_INVAL = 3'd5;
  localparam logic [2:0] OUT_FULL = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_EVICT, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
    logic [31:0] ttl;
    logic [63:0] now_time;
    logic [3:0]  requester_id;
    logic        fill_ok;
    logic [63:0] fill_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic        load_ok;
    logic [63:0] value;
    logic        stored;
    logic [4:0]  entry_count;
  } rsp_t;
endpackage

### rtl/ttl_lru_cache_with_miss_coalescing.sv
// per item: a memory scan over all entries, including the memory read latency, then a
// decide state; a stored fill adds a write state and each evicted entry adds a rank
// scan and evict step.
// one item at a time: no new item is taken until the result is taken; the result sits in
// an output register. synchronous reset clears valid bits, recency ranks, pending
// table, capacity 16. depends on tlc_pkg and the macros header
`include "ttl_lru_cache_with_miss_coalescing_macros.svh"
module ttl_lru_cache_with_miss_coalescing
  import tlc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // key[31:0], ttl[63:32], now_time[127:64], fill_ok[128], fill_value[192:129], 0 pad
  input  logic [199:0] s_tdata,
  // action[1:0], requester_id[5:2]
  input  logic [5:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // outcome[2:0], load_ok[3], value[67:4], stored[68], entry_count[73:69], 0 pad
  output logic [79:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  state_t state, state_next;
  req_t req;
  rsp_t rsp;
  logic [4:0] capacity;

  // entry memory: key, value, expiry
  logic [159:0] emem [ENTRIES];
  logic [159:0] erd;
  logic [EIDX_BITS-1:0] raddr;
  logic we;
  logic [EIDX_BITS-1:0] waddr;
  logic [159:0] wdata;

  logic [ENTRIES-1:0] evalid;
  logic [EIDX_BITS-1:0] rank [ENTRIES];
  logic [PENDING_SLOTS-1:0] pvalid, pcanc;
  logic [31:0] pkey [PENDING_SLOTS];
  logic [3:0] pown [PENDING_SLOTS];

  logic [CNT_BITS-1:0] sidx;     // scan index, running one past the last entry for read latency
  logic [EIDX_BITS-1:0] ridx;    // index of data now in erd
  logic rvld;
  logic found;
  logic [EIDX_BITS-1:0] fidx;
  logic [159:0] fdata;
  logic evicting;
  logic [EIDX_BITS-1:0] vidx;
  logic vfound;
  logic [EIDX_BITS-1:0] vrank;

  logic [CNT_BITS-1:0] count;
  logic [4:0] cap;
  always_comb begin
    count = '0;
    for (int i = 0; i < ENTRIES; i++) count = count + CNT_BITS'(evalid[i]);
    cap = (capacity > 5'(ENTRIES)) ? 5'(ENTRIES) : capacity;
  end

  // pending matches and lowest free pending slot
  logic pfound, pfree;
  logic [PIDX_BITS-1:0] pidx, fridx;
  always_comb begin
    pfound = 1'b0; pidx = '0; pfree = 1'b0; fridx = '0;
    for (int i = PENDING_SLOTS-1; i >= 0; i--) begin
      if (pvalid[i] && pkey[i] == req.key) begin
        pfound = 1'b1; pidx = PIDX_BITS'(i);
      end
      if (!pvalid[i]) begin
        pfree = 1'b1; fridx = PIDX_BITS'(i);
      end
    end
  end

  // lowest free entry
  logic efree;
  logic [EIDX_BITS-1:0] eslot;
  always_comb begin
    efree = 1'b0; eslot = '0;
    for (int i = ENTRIES-1; i >= 0; i--)
      if (!evalid[i]) begin
        efree = 1'b1; eslot = EIDX_BITS'(i);
      end
  end

  // decide-cycle result and fill control
  rsp_t dec_rsp;
  logic hit, store_go, need_evict, more_evict;
  always_comb begin
    dec_rsp = '{outcome: OUT_INVAL, load_ok: 1'b0, value: 64'd0, stored: 1'b0,
                entry_count: 5'(count)};
    store_go = 1'b0;
    hit = found && (req.now_time < fdata[159:96]);
    if (req.action == ACT_LOOKUP) begin
      if (hit) begin
        dec_rsp.outcome = OUT_HIT; dec_rsp.load_ok = 1'b1; dec_rsp.value = fdata[95:32];
      end else begin
        if (found) dec_rsp.entry_count = 5'(count - 1'b1);
        if (pfound) dec_rsp.outcome = (pown[pidx] == req.requester_id) ? OUT_RECUR : OUT_WAIT;
        else if (!pfree) dec_rsp.outcome = OUT_FULL;
        else dec_rsp.outcome = OUT_LOAD;
      end
    end else if (req.action == ACT_FILL) begin
      dec_rsp.outcome = OUT_FILL; dec_rsp.load_ok = req.fill_ok;
      dec_rsp.value = req.fill_ok ? req.fill_value : 64'd0;
      store_go = pfound && req.fill_ok && !pcanc[pidx] && cap != 5'd0 && req.ttl != 32'd0;
    end else if (req.action == ACT_INVAL) begin
      if (found) dec_rsp.entry_count = 5'(count - 1'b1);
    end
  end
  assign need_evict = 5'(count - CNT_BITS'(found)) >= cap;
  assign more_evict = vfound && (5'(count - 1'b1) >= cap);

  assign s_tready = (state == ST_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {27'd0, capacity} : 32'd0;
  assign m_tdata = {6'd0, rsp.entry_count, rsp.stored, rsp.value, rsp.load_ok, rsp.outcome};

  always_ff @(posedge clk) begin
    if (rst) capacity <= 5'd16;
    else if (psel && penable && pwrite && paddr == 2'd0) capacity <= pwdata[4:0];
  end

  assign raddr = sidx[EIDX_BITS-1:0];
  assign we = (state == ST_WRITE) && efree;
  assign waddr = eslot;
  assign wdata = {req.now_time + {32'd0, req.ttl}, req.fill_value, req.key};
  always_ff @(posedge clk) begin
    if (we) emem[waddr] <= wdata;
    erd <= emem[raddr];
  end

  logic scan_done;
  assign scan_done = (sidx == CNT_BITS'(ENTRIES)) && rvld;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SCAN;
      ST_SCAN:   if (scan_done) state_next = evicting ? ST_EVICT : ST_DECIDE;
      ST_DECIDE: state_next = store_go ? (need_evict ? ST_SCAN : ST_WRITE) : ST_OUT;
      ST_EVICT:  state_next = more_evict ? ST_SCAN : ST_WRITE;
      ST_WRITE:  state_next = ST_OUT;
      ST_OUT:    if (m_tvalid && m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // drop entry i, shifting older-than ranks down
  task automatic drop(input logic [EIDX_BITS-1:0] i);
    evalid[i] <= 1'b0;
    for (int j = 0; j < ENTRIES; j++)
      if (evalid[j] && rank[j] > rank[i] && EIDX_BITS'(j) != i) rank[j] <= rank[j] - 1'b1;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      evalid <= '0; pvalid <= '0; pcanc <= '0; m_tvalid <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) rank[i] <= '0;
      sidx <= '0; rvld <= 1'b0; found <= 1'b0; evicting <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req <= '{action: s_tuser[1:0], key: s_tdata[31:0], ttl: s_tdata[63:32],
                     now_time: s_tdata[127:64], requester_id: s_tuser[5:2],
                     fill_ok: s_tdata[128], fill_value: s_tdata[192:129]};
            sidx <= '0; rvld <= 1'b0; found <= 1'b0; evicting <= 1'b0;
          end
        end
        ST_SCAN: begin
          rvld <= 1'b1;
          ridx <= sidx[EIDX_BITS-1:0];
          if (scan_done) sidx <= '0;
          else if (sidx != CNT_BITS'(ENTRIES)) sidx <= sidx + 1'b1;
          if (rvld) begin
            if (evicting) begin
              if (evalid[ridx] && (!vfound || rank[ridx] > vrank)) begin
                vfound <= 1'b1; vidx <= ridx; vrank <= rank[ridx];
              end
            end else if (!found && evalid[ridx] && erd[31:0] == req.key) begin
              found <= 1'b1; fidx <= ridx; fdata <= erd;
            end
          end
        end
        ST_DECIDE: begin
          rsp <= dec_rsp;
          m_tvalid <= !store_go;
          if (req.action == ACT_LOOKUP) begin
            if (hit) begin
              for (int j = 0; j < ENTRIES; j++)
                if (EIDX_BITS'(j) != fidx && evalid[j] && rank[j] < rank[fidx])
                  rank[j] <= rank[j] + 1'b1;
              rank[fidx] <= '0;
            end else begin
              if (found) drop(fidx);
              if (!pfound && pfree) begin
                pvalid[fridx] <= 1'b1; pkey[fridx] <= req.key;
                pown[fridx] <= req.requester_id; pcanc[fridx] <= 1'b0;
              end
            end
          end else if (req.action == ACT_FILL) begin
            if (pfound) begin
              pvalid[pidx] <= 1'b0; pcanc[pidx] <= 1'b0;
            end
            if (store_go) begin
              if (found) drop(fidx);
              // go evict if needed
              if (need_evict) begin
                evicting <= 1'b1; vfound <= 1'b0; rvld <= 1'b0; sidx <= '0;
              end
            end
          end else if (req.action == ACT_INVAL) begin
            if (found) drop(fidx);
            if (pfound) pcanc[pidx] <= 1'b1;
          end
        end
        ST_EVICT: begin
          if (vfound) drop(vidx);
          if (more_evict) begin
            evicting <= 1'b1; vfound <= 1'b0; rvld <= 1'b0; sidx <= '0;
          end else evicting <= 1'b0;
        end
        ST_WRITE: begin
          for (int j = 0; j < ENTRIES; j++)
            if (efree && EIDX_BITS'(j) == eslot) rank[j] <= '0;
            else if (evalid[j]) rank[j] <= rank[j] + 1'b1;
          if (efree) evalid[eslot] <= 1'b1;
          rsp.stored <= efree;
          rsp.entry_count <= 5'(count + CNT_BITS'(efree));
          m_tvalid <= 1'b1;
        end
        ST_OUT: if (m_tready) m_tvalid <= 1'b0;
        default: ;
      endcase
    end
  end

  `TLC_ASSERT_IMPL(a_ready_idle, s_tready, !m_tvalid)
  `TLC_ASSERT_NEXT(a_out_release, m_tvalid && m_tready, !m_tvalid)
  `TLC_ASSERT_IMPL(a_count_bound, m_tvalid, rsp.entry_count <= 5'(ENTRIES))
endmodule
